// File: rtl/core/pnc_pkg.sv
package pnc_pkg;

  localparam int PaletteSizeDef = 256;

  localparam int ChanW  = 6;
  localparam int EntryW = 3 * ChanW;
  localparam int IdxW   = 8;
  localparam int SqW    = 2 * ChanW;
  localparam int WgW    = 24;
  localparam int WrW    = 22;
  localparam int WbW    = 19;
  localparam int DistW  = 25;

  localparam int WeightG = 59 * 59;
  localparam int WeightR = 30 * 30;
  localparam int WeightB = 11 * 11;

  localparam logic [7:0] MaskRed   = 8'd255;
  localparam logic [7:0] MaskGreen = 8'd0;
  localparam logic [7:0] MaskBlue  = 8'd255;

  localparam logic ReqWrite  = 1'b0;
  localparam logic ReqLookup = 1'b1;

  typedef logic [2:0] upc_t;

  localparam upc_t UpcFetch  = 3'd0;
  localparam upc_t UpcDecode = 3'd1;
  localparam upc_t UpcWrite  = 3'd2;
  localparam upc_t UpcInit   = 3'd3;
  localparam upc_t UpcScan   = 3'd4;
  localparam upc_t UpcDrain  = 3'd5;
  localparam upc_t UpcEmit   = 3'd6;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_LOOKUP,
    COND_SCAN_LAST,
    COND_PIPE_BUSY,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic accept;
    logic mem_we;
    logic scan_init;
    logic scan_issue;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic lookup;
    logic scan_last;
    logic pipe_busy;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    ctrl_t ctrl;
    cond_e cond;
    upc_t  target_t;
    upc_t  target_f;
  } uword_t;

  function automatic uword_t ucode_rom(upc_t a);
    uword_t w;
    w = '0;
    unique case (a)
      UpcFetch: begin
        w.ctrl.accept = 1'b1;
        w.cond        = COND_IN_VALID;
        w.target_t    = UpcDecode;
        w.target_f    = UpcFetch;
      end
      UpcDecode: begin
        w.cond     = COND_LOOKUP;
        w.target_t = UpcInit;
        w.target_f = UpcWrite;
      end
      UpcWrite: begin
        w.ctrl.mem_we = 1'b1;
        w.cond        = COND_ALWAYS;
        w.target_t    = UpcFetch;
        w.target_f    = UpcFetch;
      end
      UpcInit: begin
        w.ctrl.scan_init = 1'b1;
        w.cond           = COND_ALWAYS;
        w.target_t       = UpcScan;
        w.target_f       = UpcScan;
      end
      UpcScan: begin
        w.ctrl.scan_issue = 1'b1;
        w.cond            = COND_SCAN_LAST;
        w.target_t        = UpcDrain;
        w.target_f        = UpcScan;
      end
      UpcDrain: begin
        w.cond     = COND_PIPE_BUSY;
        w.target_t = UpcDrain;
        w.target_f = UpcEmit;
      end
      UpcEmit: begin
        w.ctrl.emit = 1'b1;
        w.cond      = COND_OUT_BUSY;
        w.target_t  = UpcEmit;
        w.target_f  = UpcFetch;
      end
      default: begin
        w.cond     = COND_ALWAYS;
        w.target_t = UpcFetch;
        w.target_f = UpcFetch;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/palette_nearest_color_search.sv
// Nearest palette colour search with weighted RGB distance.
// Input channel: in_valid_i / in_stall_o with req_type_i, entry_index_i,
// red_i, green_i, blue_i; a transfer takes place when valid is high and
// stall is low. A write item stores the top six bits of each channel at
// entry_index_i (indexes at or beyond the palette size are dropped) and
// gives no result. A lookup returns one best_index_o on the output
// channel out_valid_o / out_stall_i.
// A write item passes through fetch, decode and a write step. A lookup
// passes through fetch, decode, scan set-up, one palette read a cycle for
// every scanned entry (entry 0 is scanned only for the mask colour), the
// drain of the distance pipeline and the load of the output register.
// The palette has a single read port; one item is worked on at a time.
// Reset clears the palette to all-zero entries at once and empties the
// output register. While the receiver stalls, the result waits in the
// output register and the next item can still be taken; a further lookup
// holds in its last step until that register frees.
module palette_nearest_color_search
  import pnc_pkg::*;
#(
  parameter int PaletteSize = PaletteSizeDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] entry_index_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] best_index_o
);

  localparam int AddrW = $clog2(PaletteSize);

  ctrl_t ctrl;
  stat_t stat;

  logic             req_type_q;
  logic [IdxW-1:0]  req_idx_q;
  logic [ChanW-1:0] red6_q, green6_q, blue6_q;
  logic             mask_q;

  logic [AddrW-1:0] addr_q;
  logic             scan_last;
  logic             pal_we;
  logic [EntryW-1:0] entry;

  logic [AddrW-1:0] best_idx;
  logic             best_have;
  logic             dist_busy;

  logic             out_valid_q;
  logic [IdxW-1:0]  out_idx_q;
  logic             out_busy;
  logic             emit_fire;
  logic             in_take;

  assign in_stall_o = !ctrl.accept;
  assign in_take    = ctrl.accept && in_valid_i;
  assign scan_last  = (addr_q == AddrW'(PaletteSize - 1));
  assign pal_we     = ctrl.mem_we && (int'(req_idx_q) < PaletteSize);
  assign out_busy   = out_valid_q && out_stall_i;
  assign emit_fire  = ctrl.emit && !out_busy;

  assign stat.in_valid  = in_valid_i;
  assign stat.lookup    = (req_type_q == ReqLookup);
  assign stat.scan_last = scan_last;
  assign stat.pipe_busy = dist_busy;
  assign stat.out_busy  = out_busy;

  pnc_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  pnc_palette #(
    .PaletteSize (PaletteSize)
  ) u_palette (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pal_we),
    .waddr_i (req_idx_q[AddrW-1:0]),
    .wdata_i ({red6_q, green6_q, blue6_q}),
    .raddr_i (addr_q),
    .rdata_o (entry)
  );

  pnc_dist #(
    .PaletteSize (PaletteSize)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scan_init_i (ctrl.scan_init),
    .issue_i     (ctrl.scan_issue),
    .issue_idx_i (addr_q),
    .entry_i     (entry),
    .red6_i      (red6_q),
    .green6_i    (green6_q),
    .blue6_i     (blue6_q),
    .best_idx_o  (best_idx),
    .have_o      (best_have),
    .busy_o      (dist_busy)
  );

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_type_q <= req_type_i;
      req_idx_q  <= entry_index_i;
      red6_q     <= red_i[7:2];
      green6_q   <= green_i[7:2];
      blue6_q    <= blue_i[7:2];
      mask_q     <= (red_i == MaskRed) && (green_i == MaskGreen) &&
                    (blue_i == MaskBlue);
    end
    if (ctrl.scan_init) begin
      addr_q <= mask_q ? '0 : AddrW'(1);
    end else if (ctrl.scan_issue && !scan_last) begin
      addr_q <= addr_q + AddrW'(1);
    end
    if (emit_fire) begin
      out_idx_q <= IdxW'(best_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_index_o = out_idx_q;

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> !dist_busy)
    else $error("item taken while scan pipeline busy");

  a_emit_have: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> best_have)
    else $error("result loaded before any entry compared");

  a_scan_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.scan_issue && scan_last) |=> !ctrl.scan_issue)
    else $error("scan ran past last entry");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we |-> (!dist_busy && !ctrl.scan_issue))
    else $error("palette written during scan");

endmodule

// File: rtl/core/pnc_useq.sv
module pnc_useq
  import pnc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  upc_t   upc_q, upc_d;
  uword_t uw;
  logic   cond_hit;

  assign uw     = ucode_rom(upc_q);
  assign ctrl_o = uw.ctrl;

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_IN_VALID:  cond_hit = stat_i.in_valid;
      COND_LOOKUP:    cond_hit = stat_i.lookup;
      COND_SCAN_LAST: cond_hit = stat_i.scan_last;
      COND_PIPE_BUSY: cond_hit = stat_i.pipe_busy;
      COND_OUT_BUSY:  cond_hit = stat_i.out_busy;
      default:        cond_hit = 1'b1;
    endcase
    upc_d = cond_hit ? uw.target_t : uw.target_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UpcFetch;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// File: rtl/core/pnc_palette.sv
module pnc_palette
  import pnc_pkg::*;
#(
  parameter int PaletteSize = PaletteSizeDef,
  localparam int AddrW = $clog2(PaletteSize)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [EntryW-1:0] wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem_q [PaletteSize];
  logic [PaletteSize-1:0] written_q;
  logic [EntryW-1:0] rdata_q;
  logic              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= written_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// File: rtl/core/pnc_dist.sv
module pnc_dist
  import pnc_pkg::*;
#(
  parameter int PaletteSize = PaletteSizeDef,
  localparam int AddrW = $clog2(PaletteSize)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              scan_init_i,
  input  logic              issue_i,
  input  logic [AddrW-1:0]  issue_idx_i,
  input  logic [EntryW-1:0] entry_i,
  input  logic [ChanW-1:0]  red6_i,
  input  logic [ChanW-1:0]  green6_i,
  input  logic [ChanW-1:0]  blue6_i,
  output logic [AddrW-1:0]  best_idx_o,
  output logic              have_o,
  output logic              busy_o
);

  logic             s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [AddrW-1:0] s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic [SqW-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [WgW-1:0]   w_g_q;
  logic [WrW-1:0]   w_r_q;
  logic [WbW-1:0]   w_b_q;
  logic [DistW-1:0] dist_q;
  logic [DistW-1:0] best_dist_q;
  logic [AddrW-1:0] best_idx_q;
  logic             have_q;

  logic [ChanW-1:0] e_r, e_g, e_b;
  logic [SqW-1:0]   d_r, d_g, d_b;
  logic             take;

  assign e_r = entry_i[EntryW-1 -: ChanW];
  assign e_g = entry_i[2*ChanW-1 -: ChanW];
  assign e_b = entry_i[ChanW-1:0];

  assign d_r = SqW'((e_r >= red6_i)   ? (e_r - red6_i)   : (red6_i - e_r));
  assign d_g = SqW'((e_g >= green6_i) ? (e_g - green6_i) : (green6_i - e_g));
  assign d_b = SqW'((e_b >= blue6_i)  ? (e_b - blue6_i)  : (blue6_i - e_b));

  assign take = s4_vld_q && (!have_q || (dist_q < best_dist_q));

  always_ff @(posedge clk_i) begin
    s1_idx_q <= issue_idx_i;
    s2_idx_q <= s1_idx_q;
    sq_r_q   <= d_r * d_r;
    sq_g_q   <= d_g * d_g;
    sq_b_q   <= d_b * d_b;
    s3_idx_q <= s2_idx_q;
    w_g_q    <= WgW'(sq_g_q * WeightG);
    w_r_q    <= WrW'(sq_r_q * WeightR);
    w_b_q    <= WbW'(sq_b_q * WeightB);
    s4_idx_q <= s3_idx_q;
    dist_q   <= DistW'(w_g_q) + DistW'(w_r_q) + DistW'(w_b_q);
    if (take) begin
      best_dist_q <= dist_q;
      best_idx_q  <= s4_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      s1_vld_q <= issue_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      if (scan_init_i) begin
        have_q <= 1'b0;
      end else if (take) begin
        have_q <= 1'b1;
      end
    end
  end

  assign best_idx_o = best_idx_q;
  assign have_o     = have_q;
  assign busy_o     = s1_vld_q | s2_vld_q | s3_vld_q | s4_vld_q;

endmodule
